// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the tone mixer RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/tsm_pkg.sv -----
// Package for the square tone mixer: sizes, codes and the structs between modules.
// No dependencies.
package tsm_pkg;

  localparam int CHANNELS = 4;
  localparam int FX_DEPTH = 256;
  localparam int RAMP_TOP = 512;
  localparam int LVL_MAX  = 255;

  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FX_AW  = $clog2(FX_DEPTH);
  localparam int RAMP_W = $clog2(RAMP_TOP + 1);
  localparam int LVL_W  = 8;
  localparam int MIX_W  = $clog2(CHANNELS * LVL_MAX + 128 + RAMP_TOP + 1) + 1;
  localparam int HP_W   = 16;

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_FXWR  = 2'd3
  } op_t;

  // register map, word index
  typedef enum logic [1:0] {
    REG_VOLUME  = 2'd0,
    REG_MUTE    = 2'd1,
    REG_FX_ONLY = 2'd2,
    REG_FX_EN   = 2'd3
  } reg_idx_t;

  // tick sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAN,
    ST_FX,
    ST_EMIT
  } state_t;

  // start/stop command to the channel bank
  typedef struct packed {
    logic             start;
    logic             stop;
    logic [CH_IW-1:0] ch;
    logic [HP_W-1:0]  half_len;
    logic [LVL_W-1:0] level;
    logic             looping;
  } chan_cmd_t;

  // one channel step of the walk
  typedef struct packed {
    logic             en;
    logic [CH_IW-1:0] idx;
    logic             skip_loop;
  } chan_step_t;

endpackage

// ----- hdl/square_tone_mixer_with_ramp.sv -----
// Square tone mixer with zero-level ramp. Start, stop and effect-write beats are taken
// one per cycle while no tick is in progress and give no result. A sample tick, unless
// volume is zero or mute is set, runs one accumulator adder over the channels one per
// cycle, then adds the effect byte read from the effect RAM, then the ramp level, and
// the result lands in an output register. The input stalls for the whole tick: during
// the walk, the effect step and while the previous sample still waits in that register.
// The effect store reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed. Registers sit at byte addresses 0, 4, 8 and 12: volume,
// mute, effects_only, fx_enable.
// Depends on tsm_pkg, tsm_chan_bank, tsm_ram and assert_macros.svh.
`include "assert_macros.svh"
module square_tone_mixer_with_ramp (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [1:0]                 in_channel,
  input  logic [tsm_pkg::HP_W-1:0]   in_half_period,
  input  logic [7:0]                 in_amplitude,
  input  logic                       in_repeat_req,
  input  logic [7:0]                 in_fx_addr,
  input  logic signed [7:0]          in_fx_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_dac_duty,
  output logic [3:0]                 out_active_mask,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [3:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tsm_pkg::*;

  localparam logic [CH_IW-1:0] IDX_LAST = CH_IW'(CHANNELS - 1);
  localparam logic [FX_AW-1:0] FX_LAST  = FX_AW'(FX_DEPTH - 1);

  // configuration registers
  logic [3:0] volume_r;
  logic       mute_r;
  logic       fx_only_r;
  logic       fx_en_r;
  reg_idx_t   reg_sel;
  logic       cfg_wr;

  // sequencer and datapath state
  state_t                  state_r, state_nxt;
  logic [CH_IW-1:0]        idx_r;
  logic signed [MIX_W-1:0] mix_r;
  logic [RAMP_W-1:0]       ramp_r;
  logic [FX_AW-1:0]        fx_pos_r;
  logic                    fx_vld_r [FX_DEPTH];
  logic                    fx_hit_r;
  logic                    out_valid_r;
  logic [7:0]              duty_r;
  logic [3:0]              mask_r;

  // control
  logic                    in_acc;
  logic                    tick_go;
  logic                    fx_we;
  logic [FX_AW-1:0]        fx_waddr;
  logic                    fx_re;
  logic [7:0]              fx_rdata;
  logic                    emit_go;
  chan_cmd_t               cmd;
  chan_step_t              step;
  logic signed [LVL_W:0]   contrib;
  logic [3:0]              mask_w;

  // shared adder
  logic signed [MIX_W-1:0] opnd;
  logic signed [MIX_W-1:0] sum;
  logic signed [7:0]       fx_byte;
  logic [RAMP_W-1:0]       ramp_inc;
  logic [RAMP_W-1:0]       ramp_dec;
  logic                    mix_nz;
  logic [7:0]              duty_nxt;

  // APB register access
  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_VOLUME:  cfg_prdata = {28'd0, volume_r};
      REG_MUTE:    cfg_prdata = {31'd0, mute_r};
      REG_FX_ONLY: cfg_prdata = {31'd0, fx_only_r};
      REG_FX_EN:   cfg_prdata = {31'd0, fx_en_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r  <= 4'd6;
      mute_r    <= 1'b0;
      fx_only_r <= 1'b0;
      fx_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_VOLUME:  volume_r  <= cfg_pwdata[3:0];
        REG_MUTE:    mute_r    <= cfg_pwdata[0];
        REG_FX_ONLY: fx_only_r <= cfg_pwdata[0];
        REG_FX_EN:   fx_en_r   <= cfg_pwdata[0];
      endcase
    end
  end

  // accepted beat decode
  assign in_acc  = in_valid && !in_stall;
  assign tick_go = in_acc && (op_t'(in_op) == OP_TICK) && (volume_r != 4'd0) && !mute_r;

  always_comb begin
    cmd.start    = in_acc && (op_t'(in_op) == OP_START) &&
                   (32'(in_channel) < 32'(CHANNELS));
    cmd.stop     = in_acc && (op_t'(in_op) == OP_STOP) &&
                   (32'(in_channel) < 32'(CHANNELS));
    cmd.ch       = CH_IW'(in_channel);
    cmd.half_len = in_half_period;
    cmd.level    = in_amplitude;
    cmd.looping  = in_repeat_req;
    fx_we        = in_acc && (op_t'(in_op) == OP_FXWR) &&
                   (32'(in_fx_addr) < 32'(FX_DEPTH));
    fx_waddr     = FX_AW'(in_fx_addr);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (tick_go) state_nxt = ST_CHAN;
      ST_CHAN: if (idx_r == IDX_LAST) state_nxt = ST_FX;
      ST_FX:   state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    step.en        = (state_r == ST_CHAN);
    step.idx       = idx_r;
    step.skip_loop = fx_only_r;
    fx_re          = (state_r == ST_CHAN);
    emit_go        = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  // adder operand select
  assign fx_byte  = fx_hit_r ? $signed(fx_rdata) : 8'sd0;
  assign ramp_inc = (ramp_r < RAMP_W'(RAMP_TOP)) ? ramp_r + 1'b1 : ramp_r;
  assign ramp_dec = (ramp_r != '0) ? ramp_r - 1'b1 : ramp_r;
  assign mix_nz   = (mix_r != '0);

  always_comb begin
    case (state_r)
      ST_CHAN: opnd = MIX_W'(contrib);
      ST_FX:   opnd = fx_en_r ? MIX_W'(fx_byte) : '0;
      ST_EMIT: opnd = $signed(MIX_W'(ramp_inc));
      default: opnd = '0;
    endcase
    sum = mix_r + opnd;
  end

  // clamp at zero, keep the low byte; a silent mix shows the ramp level
  assign duty_nxt = !mix_nz ? ramp_r[7:0] : (sum[MIX_W-1] ? 8'd0 : sum[7:0]);

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      mix_r       <= '0;
      ramp_r      <= '0;
      fx_pos_r    <= '0;
      fx_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FX_DEPTH; i++) begin
        fx_vld_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (fx_we) begin
        fx_vld_r[fx_waddr] <= 1'b1;
      end
      if (fx_re) begin
        fx_hit_r <= fx_vld_r[fx_pos_r];
      end
      if (tick_go) begin
        idx_r <= '0;
        mix_r <= '0;
      end
      if (state_r == ST_CHAN) begin
        idx_r <= idx_r + 1'b1;
        mix_r <= sum;
      end
      if (state_r == ST_FX) begin
        mix_r <= sum;
        if (fx_en_r) begin
          fx_pos_r <= (fx_pos_r == FX_LAST) ? '0 : fx_pos_r + 1'b1;
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        ramp_r      <= mix_nz ? ramp_inc : ramp_dec;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      duty_r <= duty_nxt;
      mask_r <= mask_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dac_duty    = duty_r;
  assign out_active_mask = mask_r;

  tsm_chan_bank u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .step_i    (step),
    .contrib_o (contrib),
    .mask_o    (mask_w)
  );

  tsm_ram #(
    .WIDTH (8),
    .DEPTH (FX_DEPTH)
  ) u_fx_ram (
    .clk   (clk),
    .we    (fx_we),
    .waddr (fx_waddr),
    .wdata (in_fx_value),
    .re    (fx_re),
    .raddr (fx_pos_r),
    .rdata (fx_rdata)
  );

  // checks
  `ASSERT_CLK(a_ramp_cap, ramp_r <= RAMP_W'(RAMP_TOP))
  `ASSERT_CLK(a_emit_src, $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
  `ASSERT_CLK(a_chan_walk, (state_r == ST_CHAN && idx_r != IDX_LAST) |=> state_r == ST_CHAN)
  `ASSERT_CLK(a_fx_step, (state_r == ST_FX && !fx_en_r) |=> $stable(fx_pos_r))

endmodule

// ----- hdl/tsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- hdl/tsm_chan_bank.sv -----
// Square-wave channel state and the per-channel step (counter, polarity, signed level).
// Depends on tsm_pkg.
module tsm_chan_bank (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tsm_pkg::chan_cmd_t               cmd_i,
  input  tsm_pkg::chan_step_t              step_i,
  output logic signed [tsm_pkg::LVL_W:0]   contrib_o,
  output logic [3:0]                       mask_o
);
  import tsm_pkg::*;

  logic             active_r  [CHANNELS];
  logic             looping_r [CHANNELS];
  logic [HP_W-1:0]  count_r   [CHANNELS];
  logic [HP_W-1:0]  half_r    [CHANNELS];
  logic [LVL_W-1:0] level_r   [CHANNELS];
  logic             neg_r     [CHANNELS];

  logic             cur_active;
  logic             cur_loop;
  logic [HP_W-1:0]  cur_count;
  logic [HP_W-1:0]  cur_half;
  logic [LVL_W-1:0] cur_level;
  logic             cur_neg;
  logic             use_w;
  logic             wrap_w;
  logic [HP_W-1:0]  count_nxt;
  logic             neg_nxt;

  // selected channel of the walk
  always_comb begin
    cur_active = active_r[step_i.idx];
    cur_loop   = looping_r[step_i.idx];
    cur_count  = count_r[step_i.idx];
    cur_half   = half_r[step_i.idx];
    cur_level  = level_r[step_i.idx];
    cur_neg    = neg_r[step_i.idx];
  end

  // step: wrap at half length and flip polarity
  always_comb begin
    use_w     = cur_active && !(step_i.skip_loop && cur_loop);
    wrap_w    = (cur_count >= cur_half);
    count_nxt = wrap_w ? '0 : cur_count + 1'b1;
    neg_nxt   = cur_neg ^ wrap_w;
    if (!use_w) begin
      contrib_o = '0;
    end else if (neg_nxt) begin
      contrib_o = -$signed({1'b0, cur_level});
    end else begin
      contrib_o = $signed({1'b0, cur_level});
    end
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        active_r[c]  <= 1'b0;
        looping_r[c] <= 1'b0;
        count_r[c]   <= '0;
        half_r[c]    <= '0;
        level_r[c]   <= '0;
        neg_r[c]     <= 1'b0;
      end
    end else begin
      if (cmd_i.start) begin
        active_r[cmd_i.ch]  <= 1'b1;
        looping_r[cmd_i.ch] <= cmd_i.looping;
        count_r[cmd_i.ch]   <= '0;
        half_r[cmd_i.ch]    <= cmd_i.half_len;
        level_r[cmd_i.ch]   <= cmd_i.level;
        neg_r[cmd_i.ch]     <= 1'b0;
      end
      if (cmd_i.stop) begin
        active_r[cmd_i.ch] <= 1'b0;
      end
      if (step_i.en && use_w) begin
        count_r[step_i.idx] <= count_nxt;
        neg_r[step_i.idx]   <= neg_nxt;
      end
    end
  end

  // status mask shows the first four channels only
  for (genvar g = 0; g < 4; g++) begin : g_mask
    if (g < CHANNELS) begin : g_on
      assign mask_o[g] = active_r[g];
    end else begin : g_off
      assign mask_o[g] = 1'b0;
    end
  end

endmodule

// ----- bench/square_tone_mixer_with_ramp_tb.sv -----
// Self-checking bench for square_tone_mixer_with_ramp: tone, stop, effect-write and tick beats.
// A scoreboard class predicts each emitted sample; plain tasks drive the beats and the APB port.
// Depends on tsm_pkg and the square_tone_mixer_with_ramp RTL.
`timescale 1ns / 100ps

import tsm_pkg::*;

// one emitted sample as the block should present it
typedef struct {
  logic [7:0] duty;
  logic [3:0] mask;
} mix_sample_t;

// Tracks channel, effect and ramp state and queues the samples ticks should emit
class tone_mix_scoreboard;
  // register copies
  logic [3:0] volume;
  logic       mute;
  logic       fx_only;
  logic       fx_en;

  // channel bank
  logic        chan_on   [CHANNELS];
  logic        chan_loop [CHANNELS];
  logic [15:0] chan_cnt  [CHANNELS];
  logic [15:0] chan_half [CHANNELS];
  logic [7:0]  chan_lvl  [CHANNELS];
  logic        chan_neg  [CHANNELS];

  // effect store and ramp
  logic signed [7:0] fx_mem [FX_DEPTH];
  logic [7:0]        fx_pos;
  logic [9:0]        ramp;

  mix_sample_t samples_due[$];
  int          mismatches;

  function new();
    volume = 4'd6;
    mute = 1'b0;
    fx_only = 1'b0;
    fx_en = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      chan_on[c] = 1'b0;
      chan_loop[c] = 1'b0;
      chan_cnt[c] = '0;
      chan_half[c] = '0;
      chan_lvl[c] = '0;
      chan_neg[c] = 1'b0;
    end
    foreach (fx_mem[i]) fx_mem[i] = '0;
    fx_pos = '0;
    ramp = '0;
    mismatches = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_VOLUME:  volume = v[3:0];
      REG_MUTE:    mute = v[0];
      REG_FX_ONLY: fx_only = v[0];
      REG_FX_EN:   fx_en = v[0];
      default: ;
    endcase
  endfunction

  // apply one accepted input beat; a live tick queues the sample it produces
  function void note_beat(op_t op, logic [1:0] ch, logic [15:0] hp, logic [7:0] amp,
                          logic rep, logic [7:0] addr, logic signed [7:0] val);
    int          mix;
    logic [15:0] prev;
    mix_sample_t s;
    case (op)
      OP_START: begin
        chan_on[ch] = 1'b1;
        chan_loop[ch] = rep;
        chan_cnt[ch] = '0;
        chan_half[ch] = hp;
        chan_lvl[ch] = amp;
        chan_neg[ch] = 1'b0;
      end
      OP_STOP: chan_on[ch] = 1'b0;
      OP_FXWR: fx_mem[addr] = val;
      default: begin
        if (volume == 4'd0 || mute) return;
        mix = 0;
        for (int c = 0; c < CHANNELS; c++) begin
          if (!chan_on[c]) continue;
          if (fx_only && chan_loop[c]) continue;
          prev = chan_cnt[c];
          chan_cnt[c] = prev + 16'd1;
          if (prev >= chan_half[c]) begin
            chan_neg[c] = !chan_neg[c];
            chan_cnt[c] = '0;
          end
          if (chan_neg[c]) mix -= int'(chan_lvl[c]);
          else mix += int'(chan_lvl[c]);
        end
        if (fx_en) begin
          mix += int'(fx_mem[fx_pos]);
          fx_pos = (fx_pos == FX_DEPTH - 1) ? '0 : fx_pos + 8'd1;
        end
        // nonzero mix rides on the ramp, zero mix lets it decay
        if (mix != 0) begin
          if (ramp < RAMP_TOP) ramp++;
          mix += int'(ramp);
          if (mix < 0) mix = 0;
          s.duty = mix[7:0];
        end else begin
          s.duty = ramp[7:0];
          if (ramp > 0) ramp--;
        end
        s.mask = '0;
        for (int c = 0; c < CHANNELS && c < 4; c++) s.mask[c] = chan_on[c];
        samples_due.push_back(s);
      end
    endcase
  endfunction

  // compare one accepted result beat with the oldest queued sample
  function void check_sample(logic [7:0] duty, logic [3:0] mask);
    mix_sample_t s;
    if (samples_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected sample: duty %0d mask %h", duty, mask);
      return;
    end
    s = samples_due.pop_front();
    if (duty !== s.duty || mask !== s.mask) begin
      mismatches++;
      if (mismatches <= 10)
        $display("sample mismatch: expected duty %0d mask %h, got duty %0d mask %h",
                 s.duty, s.mask, duty, mask);
    end
  endfunction
endclass

module square_tone_mixer_with_ramp_tb;
  localparam int CYCLE_LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = '0;
  logic [1:0]               in_channel = '0;
  logic [HP_W-1:0]          in_half_period = '0;
  logic [7:0]               in_amplitude = '0;
  logic                     in_repeat_req = 1'b0;
  logic [7:0]               in_fx_addr = '0;
  logic signed [7:0]        in_fx_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               out_dac_duty;
  logic [3:0]               out_active_mask;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [3:0]               cfg_paddr = '0;
  logic [31:0]              cfg_pwdata = '0;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  tone_mix_scoreboard mix_sb;
  int in_idle_pct = 7;
  int out_idle_pct = 7;
  int cycles = 0;

  square_tone_mixer_with_ramp dut (.*);

  always #2 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < out_idle_pct);

  // result monitor
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) mix_sb.check_sample(out_dac_duty, out_active_mask);

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(op_t op, logic [1:0] ch, logic [15:0] hp, logic [7:0] amp,
                           logic rep, logic [7:0] addr, logic [7:0] val);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_channel <= ch;
    in_half_period <= hp;
    in_amplitude <= amp;
    in_repeat_req <= rep;
    in_fx_addr <= addr;
    in_fx_value <= val;
    do @(posedge clk); while (in_stall);
    mix_sb.note_beat(op, ch, hp, amp, rep, addr, val);
  endtask

  // random beat; unused fields carry noise
  task automatic send_random();
    int   r;
    op_t  op;
    logic [15:0] hp;
    r = $urandom_range(0, 99);
    if (r < 55) op = OP_TICK;
    else if (r < 70) op = OP_START;
    else if (r < 80) op = OP_STOP;
    else op = OP_FXWR;
    hp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    send_beat(op, 2'($urandom), hp, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic tick();
    send_beat(OP_TICK, 2'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  // hold input low until every queued sample has come out, plus tick latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mix_sb.samples_due.size() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
  endtask

  // APB write: setup then access
  task automatic set_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mix_sb.write_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic configure(logic [3:0] vol, logic mu, logic eo, logic fe);
    drain();
    set_reg(REG_VOLUME, 32'(vol));
    set_reg(REG_MUTE, 32'(mu));
    set_reg(REG_FX_ONLY, 32'(eo));
    set_reg(REG_FX_EN, 32'(fe));
  endtask

  task automatic random_run(int n);
    repeat (n) send_random();
  endtask

  initial begin
    mix_sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, empty mix, clamp, replace, stop, ramp decay
    tick();
    send_beat(OP_FXWR, 2'd0, 16'd0, 8'd0, 1'b0, 8'd0, 8'h80);
    send_beat(OP_FXWR, 2'd3, 16'hffff, 8'hff, 1'b1, 8'd255, 8'h7f);
    send_beat(OP_FXWR, 2'd1, 16'd0, 8'd0, 1'b0, 8'd1, 8'h55);
    send_beat(OP_START, 2'd0, 16'd0, 8'd255, 1'b0, 8'd0, 8'd0);
    tick();
    tick();
    send_beat(OP_START, 2'd3, 16'hffff, 8'd0, 1'b1, 8'hff, 8'hff);
    send_beat(OP_START, 2'd1, 16'd2, 8'd100, 1'b1, 8'd0, 8'd0);
    send_beat(OP_START, 2'd2, 16'd1, 8'd7, 1'b0, 8'd0, 8'd0);
    tick();
    tick();
    tick();
    send_beat(OP_STOP, 2'd0, 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    send_beat(OP_STOP, 2'd0, 16'hffff, 8'hff, 1'b1, 8'hff, 8'hff);
    tick();
    send_beat(OP_START, 2'd1, 16'd0, 8'd1, 1'b0, 8'd0, 8'd0);
    tick();
    send_beat(OP_STOP, 2'd1, 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    send_beat(OP_STOP, 2'd2, 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    send_beat(OP_STOP, 2'd3, 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    tick();
    tick();
    tick();

    // effects on, looping channels skipped, effect bytes from the store
    configure(4'd8, 1'b0, 1'b1, 1'b1);
    send_beat(OP_START, 2'd0, 16'd3, 8'd40, 1'b1, 8'd0, 8'd0);
    send_beat(OP_START, 2'd2, 16'd1, 8'd9, 1'b0, 8'd0, 8'd0);
    tick();
    tick();
    tick();

    // random phases across register settings
    configure(4'd8, 1'b0, 1'b0, 1'b1);
    random_run(30);
    drain();
    random_run(30);

    // no idling on either side
    configure(4'd15, 1'b0, 1'b1, 1'b1);
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_run(70);
    in_idle_pct = 7;
    out_idle_pct = 7;

    // suppressed ticks: mute, then zero volume
    configure(4'd15, 1'b1, 1'b0, 1'b1);
    random_run(20);
    configure(4'd0, 1'b0, 1'b0, 1'b1);
    random_run(20);

    configure(4'd1, 1'b0, 1'b0, 1'b0);
    random_run(60);

    // long steady tone: ramp climbs, then decays after stop
    configure(4'd4, 1'b0, 1'b0, 1'b0);
    for (int c = 1; c < CHANNELS; c++)
      send_beat(OP_STOP, 2'(c), 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    send_beat(OP_START, 2'd0, 16'hffff, 8'd5, 1'b0, 8'd0, 8'd0);
    repeat (80) tick();
    send_beat(OP_STOP, 2'd0, 16'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    repeat (20) tick();

    configure(4'd3, 1'b0, 1'b0, 1'b1);
    random_run(40);

    // wind down
    drain();
    repeat (20) @(posedge clk);
    if (mix_sb.mismatches == 0 && mix_sb.samples_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/tsm_pkg.sv
hdl/tsm_ram.sv
hdl/tsm_chan_bank.sv
hdl/square_tone_mixer_with_ramp.sv
bench/square_tone_mixer_with_ramp_tb.sv
